// ----- src/chained_hash_map_engine_core_assert.svh -----
// Assertion macros used by the checker file.
`ifndef CHAINED_HASH_MAP_ENGINE_CORE_ASSERT_SVH
`define CHAINED_HASH_MAP_ENGINE_CORE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define CHM_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define CHM_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/chm_pkg.sv -----
`timescale 1ns / 1ps
package chm_pkg;
  localparam int unsigned BUCKETS = 256;
  localparam int unsigned NODES   = 1024;
  localparam int unsigned BW      = $clog2(BUCKETS);
  localparam int unsigned NW      = $clog2(NODES) + 1;
  localparam int unsigned NIW     = $clog2(NODES);
  localparam logic [NW-1:0] NIL   = NW'(NODES);
  localparam logic [31:0] MIX_MULT = 32'h045d9f3b;

  typedef enum logic [1:0] {OP_PUT = 2'd0, OP_GET = 2'd1, OP_REMOVE = 2'd2, OP_NOP = 2'd3} op_t;

  // Datapath commands.
  typedef struct packed {
    logic load;       // capture request, start hash
    logic mix;        // one hash step
    logic mod_start;  // start modulo
    logic head_rd;    // read bucket head
    logic node_rd;    // read node at cur
    logic advance;    // prev <= cur, cur <= link
    logic upd_val;    // node_value[cur] <= val
    logic ins;        // allocate and link new node
    logic rem;        // unlink cur, push to free list
    logic clr_step;   // clear one bucket head
  } chm_cmd_t;

  typedef struct packed {
    logic mix_done;
    logic mod_done;
    logic cur_nil;    // cur is not a node
    logic key_hit;    // node key matches
    logic steps_out;  // walk limit reached
    logic pool_full;  // no node to allocate
    logic clr_done;
  } chm_sts_t;
endpackage

// ----- src/chained_hash_map_engine_core.sv -----
`timescale 1ns / 1ps
// Separate-chaining hash map, 32-bit keys to signed 32-bit values, one request
// at a time. A word passes through the hash (xor-shift, multiply, xor-shift,
// multiply, xor-shift, hand-off), the bucket modulo (a restoring divider,
// one bit a cycle, as the bucket count is a register) and a read of the bucket
// head; each chain node visited then passes through the check, read and compare
// states. A hit goes straight to its action, then hands its result over and
// returns to idle to take the next word. A miss makes one further end-of-chain
// check before its action. The unused opcode goes straight to the hand-over.
// After reset a sweep clears all 256 bucket heads; no word is taken until
// it ends. The result sits in an output register, so the next word is taken
// while it waits; a second result stalls in the controller until it drains.
module chained_hash_map_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // opcode[1:0], key[33:2], value[65:34], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // found[0], value_out[32:1], status[33], zero pad
);
  logic [8:0] bucket_count;
  chm_pkg::chm_cmd_t cmd;
  chm_pkg::chm_sts_t sts;
  logic busy, done, rfound, rstatus, rget;
  logic [31:0] rd_value;
  logic in_fire, out_free;

  always_ff @(posedge clk) begin
    if (rst) bucket_count <= 9'd256;
    else if (cfg_we) bucket_count <= cfg_wdata;
  end

  assign s_tready = !busy;
  assign in_fire  = s_tvalid && s_tready;
  // Result register frees when empty or being drained.
  assign out_free = !m_tvalid || m_tready;

  chm_ctrl u_ctrl (
    .clk, .rst, .in_fire, .opcode(s_tdata[1:0]), .out_free, .sts, .cmd,
    .busy, .done, .res_found(rfound), .res_status(rstatus), .res_get(rget)
  );

  chm_datapath u_dp (
    .clk, .rst, .cmd, .sts, .bucket_count, .key_in(s_tdata[33:2]),
    .val_in(s_tdata[65:34]), .rd_value
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= done || (m_tvalid && !m_tready);
      if (done) begin
        m_tdata <= {6'd0, rstatus,
                    rget ? (rfound ? rd_value : 32'hFFFF_FFFF) : 32'd0, rfound};
      end
    end
  end
endmodule

// ----- src/chm_datapath.sv -----
`timescale 1ns / 1ps
module chm_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  chm_pkg::chm_cmd_t      cmd,
  output chm_pkg::chm_sts_t      sts,
  input  logic [8:0]             bucket_count,
  input  logic [31:0]            key_in,
  input  logic [31:0]            val_in,
  output logic [31:0]            rd_value
);
  localparam int unsigned BW  = chm_pkg::BW;
  localparam int unsigned NW  = chm_pkg::NW;
  localparam int unsigned NIW = chm_pkg::NIW;
  localparam int unsigned CW  = $clog2(chm_pkg::BUCKETS + 1);
  localparam int unsigned SW  = $clog2(chm_pkg::NODES + 1);

  logic [NW-1:0]  head_mem [chm_pkg::BUCKETS];
  logic [31:0]    key_mem  [chm_pkg::NODES];
  logic [31:0]    val_mem  [chm_pkg::NODES];
  logic [NW-1:0]  link_mem [chm_pkg::NODES];

  logic [31:0] key_q, val_q, hx;
  logic [2:0]  mix_ph;
  logic [31:0] rem_r;
  logic [CW-1:0] div_r;
  logic [5:0]  mod_cnt;
  logic        mod_busy;
  logic [BW-1:0] bkt;
  logic [NW-1:0] cur, prev, head_q;
  logic [31:0]   nkey;
  logic [NW-1:0] nlink;
  logic [NW-1:0] free_link;
  logic [SW-1:0] steps;
  logic [NW-1:0] pool_used, free_head;
  logic [BW:0]   clr_idx;
  logic [CW-1:0] active;
  logic [31:0]   qsh;
  logic          pool_full_n;
  logic [NW-1:0] free_or_bump;

  always_comb begin
    if (bucket_count == 9'd0) active = CW'(1);
    else if ({23'd0, bucket_count} > 32'(chm_pkg::BUCKETS)) active = CW'(chm_pkg::BUCKETS);
    else active = CW'(bucket_count);
  end

  // Hash: phases xor, mul, xor, mul, xor.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q  <= key_in;
      val_q  <= val_in;
      hx     <= key_in;
      mix_ph <= 3'd0;
    end else if (cmd.mix) begin
      unique case (mix_ph)
        3'd1, 3'd3: hx <= hx * chm_pkg::MIX_MULT;
        default:    hx <= (hx >> 16) ^ hx;
      endcase
      mix_ph <= mix_ph + 3'd1;
    end
  end
  assign sts.mix_done = (mix_ph == 3'd5);

  // Restoring modulo, one bit a cycle from the top.
  always_ff @(posedge clk) begin
    if (rst) begin
      mod_busy <= 1'b0;
    end else if (cmd.mod_start) begin
      mod_busy <= 1'b1;
      rem_r    <= '0;
      qsh      <= hx;
      div_r    <= active;
      mod_cnt  <= '0;
    end else if (mod_busy) begin
      if ({rem_r[30:0], qsh[31]} >= {{(32-CW){1'b0}}, div_r})
        rem_r <= {rem_r[30:0], qsh[31]} - {{(32-CW){1'b0}}, div_r};
      else
        rem_r <= {rem_r[30:0], qsh[31]};
      qsh     <= {qsh[30:0], 1'b0};
      mod_cnt <= mod_cnt + 6'd1;
      if (mod_cnt == 6'd31) mod_busy <= 1'b0;
    end
  end
  assign sts.mod_done = !mod_busy && (mod_cnt == 6'd32);
  assign bkt = rem_r[BW-1:0];

  assign pool_full_n  = (free_head != chm_pkg::NIL) || (pool_used != chm_pkg::NIL);
  assign free_or_bump = (free_head != chm_pkg::NIL) ? free_head : pool_used;
  assign sts.pool_full = !pool_full_n;

  // Bucket heads with clearing sweep after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_step) begin
      head_mem[clr_idx[BW-1:0]] <= chm_pkg::NIL;
      clr_idx <= clr_idx + 1'b1;
    end else if (cmd.ins) begin
      head_mem[bkt] <= pool_full_n ? free_or_bump : head_q;
    end else if (cmd.rem && prev == chm_pkg::NIL) begin
      head_mem[bkt] <= nlink;
    end
    if (cmd.head_rd) head_q <= head_mem[bkt];
  end
  assign sts.clr_done = clr_idx[BW];

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_used <= '0;
      free_head <= chm_pkg::NIL;
    end else if (cmd.ins && pool_full_n) begin
      if (free_head != chm_pkg::NIL) free_head <= free_link;
      else pool_used <= pool_used + 1'b1;
    end else if (cmd.rem) begin
      free_head <= cur;
    end
  end

  // Node stores; read data registered. The free-list successor is fetched
  // with the bucket head, while no node read is under way.
  always_ff @(posedge clk) begin
    if (cmd.node_rd) begin
      nkey     <= key_mem[cur[NIW-1:0]];
      nlink    <= link_mem[cur[NIW-1:0]];
      rd_value <= val_mem[cur[NIW-1:0]];
    end
    if (cmd.head_rd) free_link <= link_mem[free_head[NIW-1:0]];
    if (cmd.upd_val) val_mem[cur[NIW-1:0]] <= val_q;
    if (cmd.ins && pool_full_n) begin
      key_mem[free_or_bump[NIW-1:0]]  <= key_q;
      val_mem[free_or_bump[NIW-1:0]]  <= val_q;
      link_mem[free_or_bump[NIW-1:0]] <= head_q;
    end else if (cmd.rem) begin
      link_mem[cur[NIW-1:0]] <= free_head;
      if (prev != chm_pkg::NIL) link_mem[prev[NIW-1:0]] <= nlink;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.head_rd) begin
      cur   <= head_mem[bkt];
      prev  <= chm_pkg::NIL;
      steps <= '0;
    end else if (cmd.advance) begin
      prev  <= cur;
      cur   <= nlink;
      steps <= steps + 1'b1;
    end
  end
  assign sts.cur_nil   = (cur >= chm_pkg::NIL);
  assign sts.key_hit   = (nkey == key_q);
  assign sts.steps_out = (steps == SW'(chm_pkg::NODES));
endmodule

// ----- src/chm_ctrl.sv -----
`timescale 1ns / 1ps
module chm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic [1:0]         opcode,
  input  logic               out_free,
  input  chm_pkg::chm_sts_t  sts,
  output chm_pkg::chm_cmd_t  cmd,
  output logic               busy,
  output logic               done,
  output logic               res_found,
  output logic               res_status,
  output logic               res_get
);
  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_MIX, S_MOD, S_HEAD, S_CHK, S_RD, S_CMP, S_ACT, S_DONE
  } state_t;
  state_t state;
  chm_pkg::op_t op;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_CLR:  cmd.clr_step = !sts.clr_done;
      S_IDLE: cmd.load = in_fire;
      S_MIX:  cmd.mix = !sts.mix_done;
      S_HEAD: cmd.head_rd = 1'b1;
      S_RD:   cmd.node_rd = 1'b1;
      S_CMP:  cmd.advance = !sts.key_hit;
      S_ACT: begin
        cmd.upd_val = (op == chm_pkg::OP_PUT) && res_found;
        cmd.ins     = (op == chm_pkg::OP_PUT) && !res_found;
        cmd.rem     = (op == chm_pkg::OP_REMOVE) && res_found;
      end
      default: ;
    endcase
    cmd.mod_start = (state == S_MIX) && sts.mix_done;
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLR:  if (sts.clr_done) state <= S_IDLE;
        S_IDLE: if (in_fire) begin
          op         <= chm_pkg::op_t'(opcode);
          res_found  <= 1'b0;
          res_status <= 1'b0;
          res_get    <= (opcode == chm_pkg::OP_GET);
          state      <= (opcode == chm_pkg::OP_NOP) ? S_DONE : S_MIX;
        end
        S_MIX:  if (sts.mix_done) state <= S_MOD;
        S_MOD:  if (sts.mod_done) state <= S_HEAD;
        S_HEAD: state <= S_CHK;
        S_CHK:  state <= (sts.cur_nil || sts.steps_out) ? S_ACT : S_RD;
        S_RD:   state <= S_CMP;
        S_CMP:  if (sts.key_hit) begin
          res_found <= 1'b1;
          state     <= S_ACT;
        end else begin
          state <= S_CHK;
        end
        S_ACT: begin
          if (op == chm_pkg::OP_PUT && !res_found && sts.pool_full) res_status <= 1'b1;
          state <= S_DONE;
        end
        S_DONE: if (out_free) begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- src/chm_checker.sv -----
`timescale 1ns / 1ps
`include "chained_hash_map_engine_core_assert.svh"
module chm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);
  `CHM_ASSERT_NXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
  `CHM_ASSERT_IMP(a_stat, clk, rst, m_tvalid && m_tdata[33], !m_tdata[0], "dropped put flagged found")
  `CHM_ASSERT_NXT(a_busy, clk, rst, s_tvalid && s_tready, !s_tready, "second word taken while busy")
  `CHM_ASSERT_IMP(a_pad, clk, rst, m_tvalid, m_tdata[39:34] == 6'd0, "pad bits set")
endmodule

bind chained_hash_map_engine_core chm_checker u_chk (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);

// ----- tb/sv/chained_hash_map_engine_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the chained hash map core. Directed words first, then
// random put/get/remove/nop traffic, mostly over a small key set, under several bucket
// counts, then a fresh-key pass that grows the pool and reuses freed nodes.
module chained_hash_map_engine_core_tb;

  localparam int          NBUCK    = 256;
  localparam int          NNODE    = 1024;
  localparam int          NONE     = NNODE;       // empty link / empty chain
  localparam logic [31:0] HASH_MUL = 32'h045d9f3b;
  // A bucket count of 1 can leave every node on one chain.
  localparam int          SETTLE   = 4000;

  typedef struct {
    chm_pkg::op_t op;
    logic [31:0]  key;
    logic [31:0]  val;
  } req_t;

  typedef struct {
    chm_pkg::op_t op;
    logic         found;
    logic [31:0]  vout;
    logic         status;
  } resp_t;

  typedef struct {
    chm_pkg::op_t op;
    logic [31:0]  key;
    logic [31:0]  val;
    bit           typed;
    logic         found;
    logic [31:0]  vout;
    logic         status;
  } dir_row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [8:0]  cfg_wdata = '0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;

  chained_hash_map_engine_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the map.
  int          head_of[NBUCK];
  logic [31:0] slot_key[NNODE];
  logic [31:0] slot_val[NNODE];
  int          slot_next[NNODE];
  int          bump_count;
  int          free_top;
  logic [8:0]  bucket_reg;

  resp_t       pending[$];
  logic [31:0] key_set[64];
  int          errors = 0;
  int          words_sent = 0;
  int          words_seen = 0;
  int          drops_seen = 0;
  int          hits_seen = 0;
  bit          idling = 1;

  function automatic logic [31:0] scramble(logic [31:0] x);
    x = ((x >> 16) ^ x) * HASH_MUL;
    x = ((x >> 16) ^ x) * HASH_MUL;
    return (x >> 16) ^ x;
  endfunction

  // Applies one request to the shadow map and returns what the core should say.
  function automatic resp_t map_apply(chm_pkg::op_t op, logic [31:0] key,
                                      logic [31:0] val);
    resp_t r;
    int    nb, b, cur, prev, hit, steps, nn;
    r.op = op; r.found = 0; r.vout = '0; r.status = 0;
    if (op == chm_pkg::OP_NOP) return r;
    nb = (bucket_reg == 0) ? 1 : (bucket_reg > NBUCK) ? NBUCK : int'(bucket_reg);
    b = int'(scramble(key) % nb);
    cur = head_of[b]; prev = NONE; hit = NONE; steps = 0;
    while (cur < NNODE && steps < NNODE) begin
      if (slot_key[cur] == key) begin
        hit = cur;
        break;
      end
      prev = cur;
      cur = slot_next[cur];
      steps++;
    end
    if (hit == NONE) prev = NONE;
    case (op)
      chm_pkg::OP_PUT: begin
        if (hit != NONE) begin
          slot_val[hit] = val;
          r.found = 1;
        end else begin
          if (free_top < NNODE) begin
            nn = free_top;
            free_top = slot_next[nn];
          end else if (bump_count < NNODE) begin
            nn = bump_count++;
          end else begin
            nn = NONE;
          end
          if (nn == NONE) r.status = 1;
          else begin
            slot_key[nn] = key; slot_val[nn] = val;
            slot_next[nn] = head_of[b]; head_of[b] = nn;
          end
        end
      end
      chm_pkg::OP_GET: begin
        if (hit != NONE) begin
          r.found = 1;
          r.vout = slot_val[hit];
        end else r.vout = 32'hffff_ffff;
      end
      default: begin
        if (hit != NONE) begin
          r.found = 1;
          if (prev < NNODE) slot_next[prev] = slot_next[hit];
          else head_of[b] = slot_next[hit];
          slot_next[hit] = free_top;
          free_top = hit;
        end
      end
    endcase
    return r;
  endfunction

  // Drives one word, leaving tvalid high; the expectation is queued on acceptance.
  task automatic send_word(chm_pkg::op_t op, logic [31:0] key, logic [31:0] val,
                           bit typed = 0,
                           resp_t fixed = '{chm_pkg::OP_NOP, 0, 0, 0});
    resp_t r;
    if (idling && $urandom_range(99) < 34) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 34) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, val, key, op};
    do @(posedge clk); while (!s_tready);
    r = map_apply(op, key, val);
    pending.push_back(typed ? fixed : r);
    words_sent++;
  endtask

  // Waits for every result, then idles a while before any register write.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_buckets(logic [8:0] n);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    bucket_reg = n;
  endtask

  task automatic random_words(int n);
    int           p;
    chm_pkg::op_t op;
    logic [31:0]  key;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      op = (p < 45) ? chm_pkg::OP_PUT : (p < 75) ? chm_pkg::OP_GET :
           (p < 95) ? chm_pkg::OP_REMOVE : chm_pkg::OP_NOP;
      key = ($urandom_range(7) == 0) ? $urandom() : key_set[$urandom_range(63)];
      send_word(op, key, $urandom());
    end
  endtask

  // Result side: random back-pressure, compare against the oldest expectation.
  always @(posedge clk) begin
    resp_t e;
    m_tready <= !idling || ($urandom_range(99) >= 34);
    if (!rst && m_tvalid && m_tready) begin
      words_seen++;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing expected, got %h", $time, m_tdata);
        errors++;
      end else begin
        e = pending.pop_front();
        if (m_tdata[0] !== e.found) begin
          $display("%0t: %s found expected %0b got %0b", $time, e.op.name(),
                   e.found, m_tdata[0]);
          errors++;
        end
        if (m_tdata[32:1] !== e.vout) begin
          $display("%0t: %s value_out expected %h got %h", $time, e.op.name(),
                   e.vout, m_tdata[32:1]);
          errors++;
        end
        if (m_tdata[33] !== e.status) begin
          $display("%0t: %s status expected %0b got %0b", $time, e.op.name(),
                   e.status, m_tdata[33]);
          errors++;
        end
        drops_seen += e.status;
        hits_seen  += e.found;
      end
    end
  end

  initial begin
    dir_row_t dir_tab[16];
    resp_t    fx;
    for (int i = 0; i < NBUCK; i++) head_of[i] = NONE;
    for (int i = 0; i < NNODE; i++) begin
      slot_key[i] = '0; slot_val[i] = '0; slot_next[i] = 0;
    end
    bump_count = 0; free_top = NONE; bucket_reg = 9'd256;
    key_set[0] = 32'h0; key_set[1] = 32'hffff_ffff;
    for (int i = 2; i < 64; i++) key_set[i] = $urandom();

    // Extremes, update, double remove, the unused opcode, free-list reuse.
    dir_tab = '{
      '{chm_pkg::OP_GET,    32'h0,         32'h0,         1, 0, 32'hffff_ffff, 0},
      '{chm_pkg::OP_PUT,    32'h0,         32'h8000_0000, 1, 0, 32'h0,         0},
      '{chm_pkg::OP_PUT,    32'hffff_ffff, 32'h7fff_ffff, 1, 0, 32'h0,         0},
      '{chm_pkg::OP_GET,    32'h0,         32'h0,         1, 1, 32'h8000_0000, 0},
      '{chm_pkg::OP_GET,    32'hffff_ffff, 32'h0,         1, 1, 32'h7fff_ffff, 0},
      '{chm_pkg::OP_PUT,    32'h0,         32'hffff_ffff, 1, 1, 32'h0,         0},
      '{chm_pkg::OP_GET,    32'h0,         32'h1234_5678, 1, 1, 32'hffff_ffff, 0},
      '{chm_pkg::OP_REMOVE, 32'hffff_ffff, 32'h0,         1, 1, 32'h0,         0},
      '{chm_pkg::OP_REMOVE, 32'hffff_ffff, 32'h0,         1, 0, 32'h0,         0},
      '{chm_pkg::OP_GET,    32'hffff_ffff, 32'h0,         1, 0, 32'hffff_ffff, 0},
      '{chm_pkg::OP_NOP,    32'h5,         32'h5,         1, 0, 32'h0,         0},
      '{chm_pkg::OP_PUT,    32'ha5a5_a5a5, 32'h5a5a_5a5a, 0, 0, 32'h0,         0},
      '{chm_pkg::OP_PUT,    32'h5a5a_5a5a, 32'ha5a5_a5a5, 0, 0, 32'h0,         0},
      '{chm_pkg::OP_GET,    32'ha5a5_a5a5, 32'h0,         0, 0, 32'h0,         0},
      '{chm_pkg::OP_REMOVE, 32'h0,         32'h0,         1, 1, 32'h0,         0},
      '{chm_pkg::OP_GET,    32'h0,         32'h0,         1, 0, 32'hffff_ffff, 0}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      fx = '{dir_tab[i].op, dir_tab[i].found, dir_tab[i].vout, dir_tab[i].status};
      send_word(dir_tab[i].op, dir_tab[i].key, dir_tab[i].val, dir_tab[i].typed, fx);
    end

    random_words(110);
    idling = 0;          // long stretch at full rate on both sides
    random_words(90);
    idling = 1;
    set_buckets(9'd1);   // everything on one chain
    random_words(70);
    set_buckets(9'd0);   // treated as one bucket
    random_words(50);
    set_buckets(9'd300); // clamps to the full table
    random_words(60);
    set_buckets(9'd7);
    random_words(60);
    set_buckets(9'd511);
    random_words(50);

    // Fresh keys grow the pool, then free a few nodes and reuse them.
    set_buckets(9'd256);
    for (int i = 0; i < 80; i++) send_word(chm_pkg::OP_PUT, 32'h8000_0000 + i, $urandom());
    for (int i = 0; i < 20; i++) begin
      send_word(chm_pkg::OP_REMOVE, 32'h8000_0000 + $urandom_range(79), '0);
      send_word(chm_pkg::OP_GET, 32'h8000_0000 + $urandom_range(79), '0);
      send_word(chm_pkg::OP_PUT, $urandom(), $urandom());
    end
    drain();

    $display("%0d words sent, %0d results checked: %0d hits, %0d dropped puts,",
             words_sent, words_seen, hits_seen, drops_seen);
    $display("bucket counts 256/1/0/300/7/511 visited, freed nodes reused");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("timeout with %0d results outstanding", pending.size());
    $display("end of test: mismatches");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+src
src/chm_pkg.sv
src/chm_datapath.sv
src/chm_ctrl.sv
src/chained_hash_map_engine_core.sv
src/chm_checker.sv
tb/sv/chained_hash_map_engine_core_tb.sv
